@@ src/period_window_median_macros.svh @@
// Assertion macros used by the period window median RTL.
`ifndef PERIOD_WINDOW_MEDIAN_MACROS_SVH
`define PERIOD_WINDOW_MEDIAN_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising edge outside reset.
`define PWM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PWM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PWM_ASSERT_NOW(lbl, ante, cons, msg)
`define PWM_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ src/pwm_pkg.sv @@
// Package for the period window median block: sizes, sequencer states, status type.
`default_nettype none

package pwm_pkg;

    localparam int MAX_SAMPLES = 8;
    localparam int DATA_W      = 32;
    localparam int SCOUNT_W    = 4;
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int ADDR_W      = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LOAD,
        ST_SCAN,
        ST_FINISH
    } pwm_state_t;

    typedef struct packed {
        logic idle;
        logic done;
    } pwm_status_t;

endpackage

`default_nettype wire

@@ src/pwm_sort_core.sv @@
// Sample store and selection-sort sequencer with one shared comparator.
`default_nettype none
`include "period_window_median_macros.svh"

module pwm_sort_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_accept,
    input  wire logic [pwm_pkg::DATA_W-1:0]   period_us,
    input  wire logic                         last,
    input  wire logic                         out_hold,
    output pwm_pkg::pwm_status_t              status,
    output logic      [pwm_pkg::DATA_W-1:0]   median,
    output logic      [pwm_pkg::SCOUNT_W-1:0] count
);
    import pwm_pkg::*;

    pwm_state_t          state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic [CNT_W-1:0]    i_reg, i_next;
    logic [CNT_W-1:0]    j_reg, j_next;
    logic [DATA_W-1:0]   min_reg, min_next;
    logic [DATA_W-1:0]   lo_reg, lo_next;
    logic [DATA_W-1:0]   hi_reg, hi_next;
    logic [DATA_W-1:0]   rd_data_reg;

    logic [DATA_W-1:0]   sample_mem [MAX_SAMPLES];

    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [DATA_W-1:0]   wr_data;
    logic [ADDR_W-1:0]   rd_addr;

    logic [CNT_W-1:0]    mid;
    logic                has_room;
    logic                is_less;
    logic [DATA_W-1:0]   scan_min;
    logic                load_end;
    logic                scan_end;
    logic                pass_end;
    logic                final_pass;
    logic [DATA_W:0]     pair_sum;

    assign mid        = n_reg >> 1;
    assign has_room   = count_reg < CNT_W'(MAX_SAMPLES);
    assign is_less    = rd_data_reg < min_reg;
    assign scan_min   = is_less ? rd_data_reg : min_reg;
    assign load_end   = (i_reg + CNT_W'(1)) >= n_reg;
    assign scan_end   = (j_reg + CNT_W'(1)) == n_reg;
    assign pass_end   = ((state_reg == ST_LOAD) && load_end)
                     || ((state_reg == ST_SCAN) && scan_end);
    assign final_pass = i_reg == mid;
    assign pair_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && last)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD, ST_SCAN:
            begin
                if (pass_end)
                begin
                    state_next = final_pass ? ST_FINISH : ST_FETCH;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_FINISH:
            begin
                if (!out_hold)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath control and outputs.
    always_comb
    begin
        count_next  = count_reg;
        n_next      = n_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        min_next    = min_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        wr_en       = 1'b0;
        wr_addr     = count_reg[ADDR_W-1:0];
        wr_data     = period_us;
        rd_addr     = i_reg[ADDR_W-1:0];
        status.idle = 1'b0;
        status.done = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                status.idle = 1'b1;
                if (in_accept)
                begin
                    if (has_room)
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (last)
                    begin
                        n_next     = has_room ? count_reg + CNT_W'(1) : count_reg;
                        count_next = '0;
                        i_next     = '0;
                    end
                end
            end
            ST_FETCH:
            begin
                rd_addr = i_reg[ADDR_W-1:0];
            end
            ST_LOAD:
            begin
                // The first unsorted entry seeds the running minimum.
                min_next = rd_data_reg;
                j_next   = i_reg + CNT_W'(1);
                rd_addr  = j_next[ADDR_W-1:0];
            end
            ST_SCAN:
            begin
                // A smaller entry takes the minimum's place; the old minimum
                // goes back into its slot so no value is lost.
                min_next = scan_min;
                if (is_less)
                begin
                    wr_en   = 1'b1;
                    wr_addr = j_reg[ADDR_W-1:0];
                    wr_data = min_reg;
                end
                j_next  = j_reg + CNT_W'(1);
                rd_addr = j_next[ADDR_W-1:0];
            end
            ST_FINISH:
            begin
                status.done = !out_hold;
            end
            default:
            begin
            end
        endcase

        if (pass_end)
        begin
            if (!n_reg[0] && (i_reg + CNT_W'(1)) == mid)
            begin
                lo_next = min_next;
            end
            if (final_pass)
            begin
                hi_next = min_next;
            end
            else
            begin
                i_next = i_reg + CNT_W'(1);
            end
        end
    end

    assign median = n_reg[0] ? hi_reg : pair_sum[DATA_W:1];
    assign count  = SCOUNT_W'(n_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            n_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            n_reg     <= n_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        min_reg <= min_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            sample_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= sample_mem[rd_addr];
    end

    `PWM_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_SAMPLES), "store count overflow")
    `PWM_ASSERT_NOW(a_sort_nonempty, state_reg != ST_IDLE, n_reg != '0 && i_reg <= mid, "sort out of range")
    `PWM_ASSERT_NOW(a_scan_window, state_reg == ST_SCAN, j_reg > i_reg && j_reg < n_reg, "scan index out of window")
    `PWM_ASSERT_NEXT(a_done_to_idle, status.done, state_reg == ST_IDLE, "no return to idle after result")
    `PWM_ASSERT_NEXT(a_last_starts_sort, status.idle && in_accept && last, state_reg == ST_FETCH && count_reg == '0, "marked item did not start sort")

endmodule

`default_nettype wire

@@ src/period_window_median.sv @@
// Period window median: loads up to MAX_SAMPLES periods per set, then sorts and reports the median.
//
// Each input item taken while in_ready is high is written to the sample store; items beyond
// MAX_SAMPLES in a set are dropped. After the item marked last, in_ready stays low while a
// selection sort runs on one shared comparator over the store's single read port, stopping
// once the middle position is settled. The result sits in an output register, and a new set
// may start loading while it waits to be taken.
`default_nettype none

module period_window_median (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [pwm_pkg::DATA_W-1:0]   period_us,
    input  wire logic                         last,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic      [pwm_pkg::DATA_W-1:0]   median_us,
    output logic      [pwm_pkg::SCOUNT_W-1:0] sample_count
);
    import pwm_pkg::*;

    pwm_status_t           status;
    logic [DATA_W-1:0]     core_median;
    logic [SCOUNT_W-1:0]   core_count;
    logic                  out_hold;

    logic                  out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]     median_reg;
    logic [SCOUNT_W-1:0]   sample_count_reg;

    assign in_ready = status.idle;
    assign out_hold = out_valid_reg && !out_ready;

    pwm_sort_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_valid && status.idle),
        .period_us (period_us),
        .last      (last),
        .out_hold  (out_hold),
        .status    (status),
        .median    (core_median),
        .count     (core_count)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (status.done)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (status.done)
        begin
            median_reg       <= core_median;
            sample_count_reg <= core_count;
        end
    end

    assign out_valid    = out_valid_reg;
    assign median_us    = median_reg;
    assign sample_count = sample_count_reg;

endmodule

`default_nettype wire

@@ tb/period_window_median_test.sv @@
// Self-checking testbench for the period window median block with random handshake gaps.
`default_nettype none

module period_window_median_test;

    localparam int CLK_PERIOD  = 12;
    localparam int RESET_CYC   = 8;
    localparam int ITEM_TARGET = 1800;
    localparam int TAIL_CYC    = 100;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int HOLD_CYC    = 500;
    localparam int MAX_REPORTS = 10;
    localparam int NKEEP       = pwm_pkg::MAX_SAMPLES;

    typedef logic [pwm_pkg::DATA_W-1:0]   period_t;
    typedef logic [pwm_pkg::SCOUNT_W-1:0] count_t;
    typedef period_t period_set_t [NKEEP];

    typedef struct packed {
        period_t period;
        logic    last;
    } period_item_t;

    typedef struct packed {
        period_t median;
        count_t  count;
    } median_result_t;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    in_valid     = 1'b0;
    logic    in_ready;
    period_t period_us    = '0;
    logic    last         = 1'b0;
    logic    out_valid;
    logic    out_ready    = 1'b0;
    period_t median_us;
    count_t  sample_count;

    period_item_t   pending_items[$];
    median_result_t medians_due[$];

    // Predictor copy of the block's set.
    period_set_t set_vals;
    int          set_len      = 0;

    logic        in_fire      = 1'b0;
    int          items_taken  = 0;
    int          send_gap     = 0;
    int          ready_gap    = 0;
    int          hold_left    = 0;
    int          next_hold_at = 400;
    int          mismatches   = 0;
    int          cycle_count  = 0;
    period_t     prev_period  = '0;

    period_window_median i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .period_us    (period_us),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .median_us    (median_us),
        .sample_count (sample_count)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Mostly no gap, some short ones, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic period_t pick_period();
        int r;
        r = $urandom_range(0, 11);
        case (r)
            0:       return '0;
            1:       return '1;
            2:       return period_t'($urandom_range(0, 15));
            3:       return '1 - period_t'($urandom_range(0, 15));
            4:       return prev_period;
            default: return period_t'($urandom);
        endcase
    endfunction

    function automatic median_result_t median_of_set(input period_set_t vals, input int n);
        period_set_t             s;
        period_t                 t;
        logic [pwm_pkg::DATA_W:0] pair_sum;
        median_result_t          res;
        int                      j;
        s = vals;
        for (int i = 1; i < n; i++)
        begin
            t = s[i];
            j = i - 1;
            while (j >= 0 && s[j] > t)
            begin
                s[j + 1] = s[j];
                j--;
            end
            s[j + 1] = t;
        end
        if (n % 2 == 1)
            res.median = s[n / 2];
        else
        begin
            pair_sum   = {1'b0, s[n / 2 - 1]} + {1'b0, s[n / 2]};
            res.median = pair_sum[pwm_pkg::DATA_W:1];
        end
        res.count = count_t'(n);
        return res;
    endfunction

    task automatic push_item(input period_t p, input logic is_last);
        period_item_t item;
        item.period = p;
        item.last   = is_last;
        pending_items.push_back(item);
        prev_period = p;
    endtask

    task automatic queue_set(input int len);
        for (int i = 0; i < len; i++)
            push_item(pick_period(), i == len - 1);
    endtask

    task automatic report_mismatch(input median_result_t want, input median_result_t got,
                                   input bit unexpected);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            if (unexpected)
                $display("Unexpected result: median %h count %0d", got.median, got.count);
            else
                $display("Result mismatch: expected median %h count %0d, got median %h count %0d",
                         want.median, want.count, got.median, got.count);
        end
    endtask

    // Sender: offers the next item at the falling edge, holding it until it is taken.
    always @(negedge clk)
    begin : drive_inputs
        period_item_t item;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_fire)
        begin
            if (send_gap != 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_items.size() != 0)
            begin
                item      = pending_items.pop_front();
                period_us <= item.period;
                last      <= item.last;
                in_valid  <= 1'b1;
                send_gap  <= pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Long receiver hold-offs, so the output register stays full and loading backs up.
    always @(negedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (items_taken >= next_hold_at)
        begin
            hold_left    <= HOLD_CYC;
            next_hold_at <= next_hold_at + 800;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n || hold_left != 0)
            out_ready <= 1'b0;
        else if (ready_gap != 0)
        begin
            out_ready <= 1'b0;
            ready_gap <= ready_gap - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            ready_gap <= pick_gap();
        end
    end

    always @(posedge clk)
    begin : watch_ports
        median_result_t got;
        median_result_t want;
        in_fire <= rst_n && in_valid && in_ready;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got.median = median_us;
                got.count  = sample_count;
                if (medians_due.size() == 0)
                    report_mismatch(got, got, 1'b1);
                else
                begin
                    want = medians_due.pop_front();
                    if (got.median !== want.median || got.count !== want.count)
                        report_mismatch(want, got, 1'b0);
                end
            end
            if (in_valid && in_ready)
            begin
                items_taken <= items_taken + 1;
                // Values past a full store are dropped, even a marked one.
                if (set_len < NKEEP)
                begin
                    set_vals[set_len] = period_us;
                    set_len++;
                end
                if (last)
                begin
                    medians_due.push_back(median_of_set(set_vals, set_len));
                    set_len = 0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        // Single values at both extremes.
        push_item('0, 1'b1);
        push_item('1, 1'b1);
        // Even pairs: the top pair must not wrap, the wide pair rounds down.
        push_item('1, 1'b0);
        push_item('1, 1'b1);
        push_item('0, 1'b0);
        push_item('1, 1'b1);
        // Descending odd set.
        push_item(32'd300, 1'b0);
        push_item(32'd200, 1'b0);
        push_item(32'd100, 1'b1);
        // Duplicates in an odd set.
        push_item(32'd7, 1'b0);
        push_item(32'd7, 1'b0);
        push_item(32'd3, 1'b0);
        push_item(32'd7, 1'b0);
        push_item(32'h8000_0000, 1'b1);
        // Overflowing set: the store fills and the marked value is dropped.
        for (int i = 0; i < 10; i++)
            push_item(period_t'($urandom), i == 9);

        while (pending_items.size() < ITEM_TARGET)
        begin
            if ($urandom_range(0, 99) < 85)
                queue_set($urandom_range(0, 1) ? $urandom_range(1, 3) : $urandom_range(1, NKEEP));
            else
                queue_set($urandom_range(NKEEP + 1, NKEEP + 6));
        end

        repeat (RESET_CYC) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || in_valid)
            @(posedge clk);
        while (medians_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYC) @(posedge clk);

        if (mismatches == 0 && medians_due.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
